// File: sv/assert_macros.svh
// Assertion macros used by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, switched off while reset is low.
`define CSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define CSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/css_pkg.sv
// Types, codes and constants of the coin sort sequencer.
package css_pkg;

    typedef struct packed {
        logic [11:0] light;
        logic [11:0] weight;
        logic        overlap;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  blade_angle;
        logic [7:0]  slide_angle;
        logic        coin_done;
        logic [1:0]  coin_class;
        logic [15:0] overlap_ticks;
        logic [15:0] channel_ticks;
        logic [11:0] peak_weight;
        logic        timed_out;
        logic        swing;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_SETTLE  = 4'b0010,
        PH_CHANNEL = 4'b0100,
        PH_OVERLAP = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        CFG_LIGHT_THRESHOLD = 3'd0,
        CFG_SETTLE_TICKS    = 3'd1,
        CFG_HOLDOFF_TICKS   = 3'd2,
        CFG_CHANNEL_TIMEOUT = 3'd3,
        CFG_LARGE_LIMIT     = 3'd4,
        CFG_MEDIUM_LIMIT    = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] CLASS_LARGE  = 2'd0;
    localparam logic [1:0] CLASS_MEDIUM = 2'd1;
    localparam logic [1:0] CLASS_SMALL  = 2'd2;
    localparam logic [1:0] CLASS_NONE   = 2'd3;

    localparam logic [7:0] SLIDE_LARGE  = 8'd4;
    localparam logic [7:0] SLIDE_MEDIUM = 8'd32;
    localparam logic [7:0] SLIDE_SMALL  = 8'd60;
    localparam logic [7:0] SLIDE_NONE   = 8'd88;

    localparam logic [7:0] BLADE_OPEN_ANGLE   = 8'd135;
    localparam logic [7:0] BLADE_CLOSED_ANGLE = 8'd90;
    localparam logic [6:0] BLADE_OPEN_TICKS   = 7'd100;
    localparam logic [15:0] SWING_LIMIT       = 16'd10;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

    localparam logic [11:0] RST_LIGHT_THRESHOLD = 12'd0;
    localparam logic [9:0]  RST_SETTLE_TICKS    = 10'd500;
    localparam logic [9:0]  RST_HOLDOFF_TICKS   = 10'd500;
    localparam logic [15:0] RST_CHANNEL_TIMEOUT = 16'd6000;
    localparam logic [15:0] RST_LARGE_LIMIT     = 16'd125;
    localparam logic [15:0] RST_MEDIUM_LIMIT    = 16'd90;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

// File: sv/coin_sort_sequencer.sv
// Coin sort sequencer: detection, settle, channel and overlap timing, classing.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  in       | to block  | i_in_valid / o_in_stall   | i_in_item  (one tick)
//  out      | from      | o_out_valid / i_out_stall | o_out_item (one per tick)
//  cfg      | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls: an input register, one stage of counter
// and compare logic, then the result register.
// The sequencer state advances when an item moves from the input to the result register.
// Stall on the output holds the result register; the input stalls only when both are full.
// Reset is synchronous: phase idle, timers and counters zero, slide at 4 degrees.
`include "assert_macros.svh"

module coin_sort_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  css_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output css_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    // configuration
    logic [11:0] r_light_threshold;
    logic [9:0]  r_settle_ticks;
    logic [9:0]  r_holdoff_ticks;
    logic [15:0] r_channel_timeout;
    logic [15:0] r_large_limit;
    logic [15:0] r_medium_limit;

    // pipeline
    logic               r_in_valid;
    css_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    css_pkg::t_out_item r_out_item;
    logic               w_adv;

    // sequencer state
    css_pkg::t_phase r_phase, n_phase;
    logic [9:0]  r_phase_count, n_phase_count;
    logic [15:0] r_channel_count, n_channel_count;
    logic [15:0] r_overlap_count, n_overlap_count;
    logic [11:0] r_weight_peak, n_weight_peak;
    logic [6:0]  r_blade_timer, n_blade_timer;
    logic [9:0]  r_holdoff_timer, n_holdoff_timer;
    logic [7:0]  r_slide_position, n_slide_position;
    css_pkg::t_out_item n_out_item;

    logic        w_done;
    logic        w_tmo;
    logic [1:0]  w_class;
    logic [15:0] w_ch_inc;

    assign o_cfg_ready = 1'b1;
    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_threshold <= css_pkg::RST_LIGHT_THRESHOLD;
            r_settle_ticks    <= css_pkg::RST_SETTLE_TICKS;
            r_holdoff_ticks   <= css_pkg::RST_HOLDOFF_TICKS;
            r_channel_timeout <= css_pkg::RST_CHANNEL_TIMEOUT;
            r_large_limit     <= css_pkg::RST_LARGE_LIMIT;
            r_medium_limit    <= css_pkg::RST_MEDIUM_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                css_pkg::CFG_LIGHT_THRESHOLD: r_light_threshold <= i_cfg_data[11:0];
                css_pkg::CFG_SETTLE_TICKS:    r_settle_ticks    <= i_cfg_data[9:0];
                css_pkg::CFG_HOLDOFF_TICKS:   r_holdoff_ticks   <= i_cfg_data[9:0];
                css_pkg::CFG_CHANNEL_TIMEOUT: r_channel_timeout <= i_cfg_data;
                css_pkg::CFG_LARGE_LIMIT:     r_large_limit     <= i_cfg_data;
                css_pkg::CFG_MEDIUM_LIMIT:    r_medium_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_blade_timer    = (r_blade_timer != 7'd0) ? r_blade_timer - 7'd1 : r_blade_timer;
        n_holdoff_timer  = (r_holdoff_timer != 10'd0) ? r_holdoff_timer - 10'd1
                                                      : r_holdoff_timer;
        n_phase          = r_phase;
        n_phase_count    = r_phase_count;
        n_channel_count  = r_channel_count;
        n_overlap_count  = r_overlap_count;
        n_weight_peak    = r_weight_peak;
        n_slide_position = r_slide_position;
        w_done           = 1'b0;
        w_tmo            = 1'b0;
        w_class          = css_pkg::CLASS_LARGE;
        w_ch_inc         = css_pkg::sat_inc(r_channel_count);

        unique case (r_phase)
            css_pkg::PH_IDLE: begin
                if (n_holdoff_timer == 10'd0 && r_in_item.light < r_light_threshold) begin
                    n_phase       = css_pkg::PH_SETTLE;
                    n_phase_count = r_settle_ticks;
                end
            end
            css_pkg::PH_SETTLE: begin
                if (r_phase_count == 10'd0) begin
                    n_blade_timer   = css_pkg::BLADE_OPEN_TICKS;
                    n_holdoff_timer = r_holdoff_ticks;
                    n_channel_count = '0;
                    n_overlap_count = '0;
                    n_weight_peak   = '0;
                    n_phase         = css_pkg::PH_CHANNEL;
                end else begin
                    n_phase_count = r_phase_count - 10'd1;
                end
            end
            css_pkg::PH_CHANNEL: begin
                if (r_in_item.weight > r_weight_peak) n_weight_peak = r_in_item.weight;
                if (r_in_item.overlap) begin
                    n_overlap_count = 16'd1;
                    n_phase         = css_pkg::PH_OVERLAP;
                end else begin
                    n_channel_count = w_ch_inc;
                    if (w_ch_inc >= r_channel_timeout) begin
                        n_overlap_count = '0;
                        w_tmo           = 1'b1;
                        w_done          = 1'b1;
                    end
                end
            end
            css_pkg::PH_OVERLAP: begin
                if (r_in_item.overlap) n_overlap_count = css_pkg::sat_inc(r_overlap_count);
                else w_done = 1'b1;
            end
            default: n_phase = css_pkg::PH_IDLE;
        endcase

        if (w_done) begin
            n_phase = css_pkg::PH_IDLE;
            priority if (n_overlap_count > r_large_limit) begin
                w_class          = css_pkg::CLASS_LARGE;
                n_slide_position = css_pkg::SLIDE_LARGE;
            end else if (n_overlap_count > r_medium_limit) begin
                w_class          = css_pkg::CLASS_MEDIUM;
                n_slide_position = css_pkg::SLIDE_MEDIUM;
            end else if (n_overlap_count != 16'd0) begin
                w_class          = css_pkg::CLASS_SMALL;
                n_slide_position = css_pkg::SLIDE_SMALL;
            end else begin
                w_class          = css_pkg::CLASS_NONE;
                n_slide_position = css_pkg::SLIDE_NONE;
            end
        end

        n_out_item             = '0;
        n_out_item.blade_angle = (n_blade_timer != 7'd0) ? css_pkg::BLADE_OPEN_ANGLE
                                                         : css_pkg::BLADE_CLOSED_ANGLE;
        n_out_item.slide_angle = n_slide_position;
        if (w_done) begin
            n_out_item.coin_done     = 1'b1;
            n_out_item.coin_class    = w_class;
            n_out_item.overlap_ticks = n_overlap_count;
            n_out_item.channel_ticks = n_channel_count;
            n_out_item.peak_weight   = n_weight_peak;
            n_out_item.timed_out     = w_tmo;
            n_out_item.swing         = !w_tmo && (n_overlap_count <= css_pkg::SWING_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_phase          <= css_pkg::PH_IDLE;
            r_phase_count    <= '0;
            r_channel_count  <= '0;
            r_overlap_count  <= '0;
            r_weight_peak    <= '0;
            r_blade_timer    <= '0;
            r_holdoff_timer  <= '0;
            r_slide_position <= css_pkg::SLIDE_LARGE;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (w_adv) begin
                r_out_valid      <= 1'b1;
                r_phase          <= n_phase;
                r_phase_count    <= n_phase_count;
                r_channel_count  <= n_channel_count;
                r_overlap_count  <= n_overlap_count;
                r_weight_peak    <= n_weight_peak;
                r_blade_timer    <= n_blade_timer;
                r_holdoff_timer  <= n_holdoff_timer;
                r_slide_position <= n_slide_position;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_in_item <= i_in_item;
        if (w_adv) r_out_item <= n_out_item;
    end

    `CSS_ASSERT(a_done_idle, i_clk, i_rst_n, (r_out_valid && r_out_item.coin_done && $past(w_adv)) |-> (r_phase == css_pkg::PH_IDLE), "completed coin left the sequencer busy")

    `CSS_ASSERT(a_tmo_class, i_clk, i_rst_n, (r_out_valid && r_out_item.timed_out) |-> (r_out_item.coin_class == css_pkg::CLASS_NONE && !r_out_item.swing), "timeout not reported as unrecognised")

    `CSS_ASSERT(a_slide_class, i_clk, i_rst_n, (r_out_valid && r_out_item.coin_done) |-> ((r_out_item.coin_class == css_pkg::CLASS_LARGE && r_out_item.slide_angle == css_pkg::SLIDE_LARGE) || (r_out_item.coin_class == css_pkg::CLASS_MEDIUM && r_out_item.slide_angle == css_pkg::SLIDE_MEDIUM) || (r_out_item.coin_class == css_pkg::CLASS_SMALL && r_out_item.slide_angle == css_pkg::SLIDE_SMALL) || (r_out_item.coin_class == css_pkg::CLASS_NONE && r_out_item.slide_angle == css_pkg::SLIDE_NONE)), "slide angle does not match class")

    `CSS_ASSERT(a_adv_out, i_clk, i_rst_n, w_adv |=> r_out_valid, "advanced item lost before the result register")

endmodule

// File: dv/coin_sort_checker.sv
// Checker for the coin sort sequencer: tracks the channels, predicts each tick report, compares.
`timescale 1ns / 1ps

module coin_sort_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  css_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  css_pkg::t_out_item  i_out_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import css_pkg::*;

    logic [11:0] thr;
    logic [9:0]  settle_len;
    logic [9:0]  hold_len;
    logic [15:0] tmo_len;
    logic [15:0] large_lim;
    logic [15:0] medium_lim;

    t_phase      ph;
    logic [15:0] ph_cnt;
    logic [15:0] chan_cnt;
    logic [15:0] ovl_cnt;
    logic [11:0] w_peak;
    logic [6:0]  blade_tmr;
    logic [9:0]  hold_tmr;
    logic [7:0]  slide_pos;

    t_out_item   tick_report_q[$];
    int          n_fail = 0;

    function automatic t_out_item sort_tick(input t_in_item it);
        t_out_item  r;
        logic       done;
        logic       tmo;
        logic [1:0] cls;
        done = 1'b0;
        tmo  = 1'b0;
        cls  = CLASS_LARGE;
        if (blade_tmr != 7'd0) blade_tmr = blade_tmr - 7'd1;
        if (hold_tmr != 10'd0) hold_tmr = hold_tmr - 10'd1;

        case (ph)
            PH_IDLE: begin
                if (hold_tmr == 10'd0 && it.light < thr) begin
                    ph     = PH_SETTLE;
                    ph_cnt = settle_len;
                end
            end
            PH_SETTLE: begin
                if (ph_cnt == 16'd0) begin
                    blade_tmr = BLADE_OPEN_TICKS;
                    hold_tmr  = hold_len;
                    chan_cnt  = 16'd0;
                    ovl_cnt   = 16'd0;
                    w_peak    = 12'd0;
                    ph        = PH_CHANNEL;
                end else begin
                    ph_cnt = ph_cnt - 16'd1;
                end
            end
            PH_CHANNEL: begin
                if (it.weight > w_peak) w_peak = it.weight;
                if (it.overlap) begin
                    ovl_cnt = 16'd1;
                    ph      = PH_OVERLAP;
                end else begin
                    chan_cnt = (chan_cnt == COUNT_MAX) ? chan_cnt : chan_cnt + 16'd1;
                    if (chan_cnt >= tmo_len) begin
                        ovl_cnt = 16'd0;
                        tmo     = 1'b1;
                        done    = 1'b1;
                    end
                end
            end
            default: begin
                if (it.overlap) begin
                    ovl_cnt = (ovl_cnt == COUNT_MAX) ? ovl_cnt : ovl_cnt + 16'd1;
                end else begin
                    done = 1'b1;
                end
            end
        endcase

        if (done) begin
            ph = PH_IDLE;
            if (ovl_cnt > large_lim) begin
                cls       = CLASS_LARGE;
                slide_pos = SLIDE_LARGE;
            end else if (ovl_cnt > medium_lim) begin
                cls       = CLASS_MEDIUM;
                slide_pos = SLIDE_MEDIUM;
            end else if (ovl_cnt > 16'd0) begin
                cls       = CLASS_SMALL;
                slide_pos = SLIDE_SMALL;
            end else begin
                cls       = CLASS_NONE;
                slide_pos = SLIDE_NONE;
            end
        end

        r             = '0;
        r.blade_angle = (blade_tmr != 7'd0) ? BLADE_OPEN_ANGLE : BLADE_CLOSED_ANGLE;
        r.slide_angle = slide_pos;
        if (done) begin
            r.coin_done     = 1'b1;
            r.coin_class    = cls;
            r.overlap_ticks = ovl_cnt;
            r.channel_ticks = chan_cnt;
            r.peak_weight   = w_peak;
            r.timed_out     = tmo;
            r.swing         = !tmo && ovl_cnt <= SWING_LIMIT;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            thr        = RST_LIGHT_THRESHOLD;
            settle_len = RST_SETTLE_TICKS;
            hold_len   = RST_HOLDOFF_TICKS;
            tmo_len    = RST_CHANNEL_TIMEOUT;
            large_lim  = RST_LARGE_LIMIT;
            medium_lim = RST_MEDIUM_LIMIT;
            ph         = PH_IDLE;
            ph_cnt     = 16'd0;
            chan_cnt   = 16'd0;
            ovl_cnt    = 16'd0;
            w_peak     = 12'd0;
            blade_tmr  = 7'd0;
            hold_tmr   = 10'd0;
            slide_pos  = SLIDE_LARGE;
            tick_report_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (tick_report_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) $display("unexpected tick report %p", i_out_item);
                end else begin
                    want = tick_report_q.pop_front();
                    if (i_out_item !== want) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("mismatch (exp/act): blade %0d/%0d slide %0d/%0d done %0b/%0b",
                                     want.blade_angle, i_out_item.blade_angle,
                                     want.slide_angle, i_out_item.slide_angle,
                                     want.coin_done, i_out_item.coin_done);
                            $display("  class %0d/%0d ovl %0d/%0d chan %0d/%0d peak %0d/%0d",
                                     want.coin_class, i_out_item.coin_class,
                                     want.overlap_ticks, i_out_item.overlap_ticks,
                                     want.channel_ticks, i_out_item.channel_ticks,
                                     want.peak_weight, i_out_item.peak_weight);
                            $display("  timed_out %0b/%0b swing %0b/%0b",
                                     want.timed_out, i_out_item.timed_out,
                                     want.swing, i_out_item.swing);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) tick_report_q.push_back(sort_tick(i_in_item));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LIGHT_THRESHOLD: thr        = i_cfg_data[11:0];
                    CFG_SETTLE_TICKS:    settle_len = i_cfg_data[9:0];
                    CFG_HOLDOFF_TICKS:   hold_len   = i_cfg_data[9:0];
                    CFG_CHANNEL_TIMEOUT: tmo_len    = i_cfg_data;
                    CFG_LARGE_LIMIT:     large_lim  = i_cfg_data;
                    CFG_MEDIUM_LIMIT:    medium_lim = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= tick_report_q.size();
    end

endmodule

// File: dv/coin_sort_sequencer_test.sv
// Testbench top for the coin sort sequencer: clock, reset, tick stimulus, register writes, verdict.
`timescale 1ns / 1ps

module coin_sort_sequencer_test;
    import css_pkg::*;

    localparam int         CYCLE_LIMIT  = 200_000;
    localparam logic [2:0] IDX_SPARE_LO = 3'd6;
    localparam logic [2:0] IDX_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        idle_on   = 1'b0;

    logic        in_stall;
    logic        out_valid;
    t_out_item   out_item;
    logic        cfg_ready;
    int          fail_count;
    int          pending;

    int          burst_left = 0;
    int          cycles     = 0;
    int          n_sent     = 0;
    int          phase_end;

    logic [11:0] cur_thr;
    logic [9:0]  cur_settle;
    logic [9:0]  cur_hold;
    logic [15:0] cur_tmo;

    coin_sort_sequencer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    coin_sort_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** coin_sort_sequencer: FAILED **");
            $finish;
        end
    end

    // receiver stalls in bursts of random length
    always @(posedge clk) begin
        if (!rst_n || !idle_on) begin
            out_stall  <= 1'b0;
            burst_left <= 0;
        end else if (burst_left > 1) begin
            burst_left <= burst_left - 1;
        end else if (burst_left == 1) begin
            out_stall  <= 1'b0;
            burst_left <= 0;
        end else if ($urandom_range(0, 9) == 0) begin
            out_stall  <= 1'b1;
            burst_left <= $urandom_range(1, 16);
        end
    end

    function automatic logic [11:0] rnd12();
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [11:0] light_lo();
        return 12'($urandom_range(0, cur_thr - 1));
    endfunction

    function automatic logic [11:0] light_hi();
        return 12'($urandom_range(cur_thr, 4095));
    endfunction

    task automatic send_tick(input logic [11:0] l, input logic [11:0] w, input logic o);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{light: l, weight: w, overlap: o};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // narrow registers get random upper bits, which the block must drop
    task automatic set_regs(input logic [11:0] t, input logic [9:0] s, input logic [9:0] h,
                            input logic [15:0] tm, input logic [15:0] lg, input logic [15:0] md);
        logic [3:0] j4;
        logic [5:0] j6;
        j4 = 4'($urandom);
        j6 = 6'($urandom);
        write_reg(CFG_LIGHT_THRESHOLD, {j4, t});
        write_reg(CFG_SETTLE_TICKS, {j6, s});
        j6 = 6'($urandom);
        write_reg(CFG_HOLDOFF_TICKS, {j6, h});
        write_reg(CFG_CHANNEL_TIMEOUT, tm);
        write_reg(CFG_LARGE_LIMIT, lg);
        write_reg(CFG_MEDIUM_LIMIT, md);
        cur_thr    = t;
        cur_settle = s;
        cur_hold   = h;
        cur_tmo    = tm;
    endtask

    // one coin: detection, settle, channel, overlap, end, then idle past the holdoff
    task automatic run_coin(input int chan_n, input int ovl_n);
        int rem;
        int rest_n;
        send_tick(light_lo(), rnd12(), rnd_bit());
        repeat (cur_settle + 1) send_tick(rnd12(), rnd12(), rnd_bit());
        repeat (chan_n) send_tick(light_hi(), rnd12(), 1'b0);
        repeat (ovl_n) send_tick(light_hi(), rnd12(), 1'b1);
        send_tick(light_hi(), rnd12(), 1'b0);
        rem    = cur_hold - (chan_n + ovl_n + 1);
        rest_n = ((rem > 1) ? rem - 1 : 0) + $urandom_range(0, 3);
        for (int j = 1; j <= rest_n; j++) begin
            if (j < rem && $urandom_range(0, 2) == 0) send_tick(light_lo(), rnd12(), rnd_bit());
            else send_tick(light_hi(), rnd12(), rnd_bit());
        end
    endtask

    task automatic random_coin();
        if ($urandom_range(0, 4) == 0) begin
            run_coin((cur_tmo == 16'd0) ? 1 : cur_tmo, 0);
        end else begin
            run_coin((cur_tmo > 16'd1) ? $urandom_range(0, cur_tmo - 1) : 0,
                     $urandom_range(1, 20));
        end
    endtask

    task automatic random_regs();
        set_regs(12'($urandom_range(1, 4095)), 10'($urandom_range(0, 6)),
                 10'($urandom_range(0, 24)), 16'($urandom_range(0, 24)),
                 16'($urandom_range(0, 16)), 16'($urandom_range(0, 12)));
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n   <= 1'b1;
        idle_on <= 1'b1;
        @(posedge clk);

        // reset registers: threshold zero, so no coin is ever detected
        send_tick(12'd0, 12'd0, 1'b0);
        send_tick(12'hFFF, 12'hFFF, 1'b1);
        send_tick(12'd0, 12'hFFF, 1'b0);
        send_tick(12'hFFF, 12'd0, 1'b1);
        send_tick(12'hAAA, 12'h555, 1'b1);
        send_tick(12'h555, 12'hAAA, 1'b0);
        drain_results();

        // short coins of each class, zero settle; spare indexes must be ignored
        set_regs(12'hFFF, 10'd0, 10'd0, 16'd3, 16'd2, 16'd1);
        write_reg(IDX_SPARE_LO, 16'hFFFF);
        write_reg(IDX_SPARE_HI, 16'h0000);
        run_coin(0, 3);
        run_coin(1, 2);
        run_coin(2, 1);
        run_coin(3, 0);
        drain_results();

        // long settle and holdoff, zero timeout and limits
        set_regs(12'd1, 10'd30, 10'd40, 16'd0, 16'd0, 16'd0);
        run_coin(1, 0);
        run_coin(0, 5);
        drain_results();

        // limits at the top: every coin that does not time out sorts small
        set_regs(12'hFFF, 10'd0, 10'd0, 16'd1, 16'hFFFF, 16'hFFFF);
        repeat (8) random_coin();
        drain_results();

        phase_end = n_sent + 350;
        while (n_sent < phase_end) begin
            drain_results();
            random_regs();
            repeat (6) begin
                if ($urandom_range(0, 15) == 0) drain_results();
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 8)) send_tick(rnd12(), rnd12(), rnd_bit());
                    repeat (cur_settle + cur_tmo + cur_hold + 4)
                        send_tick(light_hi(), rnd12(), 1'b0);
                end else begin
                    random_coin();
                end
            end
        end

        // no idling from here
        drain_results();
        idle_on <= 1'b0;
        random_regs();
        repeat (6) random_coin();
        drain_results();
        repeat (8) @(posedge clk);

        if (fail_count == 0) begin
            $display("** coin_sort_sequencer: PASSED **");
        end else begin
            $display("** coin_sort_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
